FILE: sv/hpr_pkg.sv
// Package of shared types and constants for the HSV palette ramp generator.
package hpr_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAMP_MODE  = 2'd0,
    CFG_BASE_HUE   = 2'd1,
    CFG_DESCENDING = 2'd2,
    CFG_HUE_SKIP   = 2'd3
  } hpr_cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_RAINBOW  = 3'd0,
    MODE_VALUE    = 3'd1,
    MODE_SAT      = 3'd2,
    MODE_GRAY     = 3'd3,
    MODE_SPECTRUM = 3'd4
  } hpr_mode_t;

  // Hue sectors of the conversion, each 43 hue steps wide but the last, which is 41 wide.
  typedef enum logic [2:0] {
    RGN_RY = 3'd0,
    RGN_YG = 3'd1,
    RGN_GC = 3'd2,
    RGN_CB = 3'd3,
    RGN_BM = 3'd4,
    RGN_MR = 3'd5
  } hpr_region_t;

  localparam logic [7:0] SECTOR_W = 8'd43;

  typedef struct packed {
    logic [2:0] ramp_mode;
    logic [7:0] base_hue;
    logic       descending;
    logic [5:0] hue_skip;
  } hpr_cfg_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] idx;
  } hpr_hsv_t;

endpackage

FILE: sv/hpr_if.sv
// Valid/ready channel interfaces for the slot input and the palette entry output.
interface hpr_slot_if;
  logic       valid;
  logic       ready;
  logic [7:0] slot;

  modport source(output valid, output slot, input ready);
  modport sink(input valid, input slot, output ready);
endinterface

interface hpr_entry_if;
  logic        valid;
  logic        ready;
  logic [7:0]  entry_index;
  logic [14:0] color_word;

  modport source(output valid, output entry_index, output color_word, input ready);
  modport sink(input valid, input entry_index, input color_word, output ready);
endinterface

FILE: sv/hpr_sel.sv
// First pipeline stage: maps a slot and the ramp settings to hue, saturation, value and index.
module hpr_sel (
  input  logic              clk,
  input  logic              rst_n,
  input  hpr_pkg::hpr_cfg_t cfg,
  hpr_slot_if.sink          in_ch,
  output logic              hsv_valid,
  output hpr_pkg::hpr_hsv_t hsv,
  input  logic              hsv_ready
);

  logic              vld_r;
  hpr_pkg::hpr_hsv_t hsv_r;
  hpr_pkg::hpr_hsv_t hsv_nxt;
  logic              rdy;
  logic [7:0]        j;
  logic [7:0]        mirrored;
  logic [8:0]        skip_prod;
  logic [7:0]        spec_hue;

  assign rdy         = !vld_r || hsv_ready;
  assign in_ch.ready = rdy;
  assign j           = in_ch.slot - 8'd1;
  assign mirrored    = 8'd0 - in_ch.slot;
  assign skip_prod   = 9'(cfg.hue_skip) * 9'(j[7:5]);
  assign spec_hue    = cfg.base_hue + {skip_prod[5:0], 2'b00};

  always_comb begin
    hsv_nxt.hue = 8'd0;
    hsv_nxt.sat = 8'd0;
    hsv_nxt.val = 8'd0;
    hsv_nxt.idx = in_ch.slot;
    case (hpr_pkg::hpr_mode_t'(cfg.ramp_mode))
      hpr_pkg::MODE_RAINBOW: begin
        hsv_nxt.hue = j;
        hsv_nxt.sat = 8'hFF;
        hsv_nxt.val = 8'hFF;
      end
      hpr_pkg::MODE_VALUE: begin
        hsv_nxt.hue = cfg.base_hue;
        hsv_nxt.sat = 8'hFF;
        hsv_nxt.val = j;
        if (cfg.descending) begin
          hsv_nxt.idx = mirrored;
        end
      end
      hpr_pkg::MODE_SAT: begin
        hsv_nxt.hue = cfg.base_hue;
        hsv_nxt.sat = j;
        hsv_nxt.val = 8'hFF;
        if (cfg.descending) begin
          hsv_nxt.idx = mirrored;
        end
      end
      hpr_pkg::MODE_GRAY: begin
        hsv_nxt.val = in_ch.slot;
        if (cfg.descending) begin
          hsv_nxt.idx = mirrored;
        end
      end
      hpr_pkg::MODE_SPECTRUM: begin
        hsv_nxt.hue = spec_hue;
        hsv_nxt.sat = 8'hFF;
        hsv_nxt.val = {1'b1, j[4:0], 2'b00};
      end
      default: begin
        hsv_nxt.val = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_ch.valid) begin
      hsv_r <= hsv_nxt;
    end
  end

  assign hsv_valid = vld_r;
  assign hsv       = hsv_r;

  a_rainbow_full : assert property (@(posedge clk) disable iff (!rst_n)
    (rdy && in_ch.valid && cfg.ramp_mode == hpr_pkg::MODE_RAINBOW)
      |=> (hsv_r.sat == 8'hFF && hsv_r.val == 8'hFF))
    else $error("rainbow entry without full saturation and value");

  a_mirror : assert property (@(posedge clk) disable iff (!rst_n)
    (rdy && in_ch.valid && cfg.descending &&
     (cfg.ramp_mode == hpr_pkg::MODE_VALUE || cfg.ramp_mode == hpr_pkg::MODE_SAT ||
      cfg.ramp_mode == hpr_pkg::MODE_GRAY))
      |=> (8'(hsv_r.idx + $past(in_ch.slot)) == 8'd0))
    else $error("descending index is not the mirror of the slot");

endmodule

FILE: sv/hpr_conv.sv
// Four pipeline stages of integer HSV to RGB conversion and 555 packing.
module hpr_conv (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              hsv_valid,
  input  hpr_pkg::hpr_hsv_t hsv,
  output logic              hsv_ready,
  hpr_entry_if.source       out_ch
);

  logic        vld2_r, vld3_r, vld4_r, vld5_r;
  logic        rdy2, rdy3, rdy4, rdy5;

  // Stage 2: sector, remainder and p.
  logic [2:0]  rgn2_r;
  logic [7:0]  rem2_r, p2_r, v2_r, s2_r, idx2_r;
  logic        gray2_r;
  logic [2:0]  rgn_nxt;
  logic [7:0]  base_nxt;
  logic [7:0]  off_nxt;
  logic [7:0]  rem6_nxt;
  logic [15:0] p_prod;

  // Stage 3: saturation products.
  logic [2:0]  rgn3_r;
  logic [7:0]  sr3_r, st3_r, p3_r, v3_r, idx3_r;
  logic        gray3_r;
  logic [15:0] sr_prod, st_prod;

  // Stage 4: q and t.
  logic [2:0]  rgn4_r;
  logic [7:0]  q4_r, t4_r, p4_r, v4_r, idx4_r;
  logic        gray4_r;
  logic [15:0] q_prod, t_prod;

  // Stage 5: output word.
  logic [7:0]  idx5_r;
  logic [14:0] col5_r;
  logic        gray5_r;
  logic [7:0]  red, grn, blu;
  logic [14:0] col_nxt;

  assign rdy5      = !vld5_r || out_ch.ready;
  assign rdy4      = !vld4_r || rdy5;
  assign rdy3      = !vld3_r || rdy4;
  assign rdy2      = !vld2_r || rdy3;
  assign hsv_ready = rdy2;

  always_comb begin
    if (hsv.hue < 8'd43) begin
      rgn_nxt  = hpr_pkg::RGN_RY;
      base_nxt = 8'd0;
    end else if (hsv.hue < 8'd86) begin
      rgn_nxt  = hpr_pkg::RGN_YG;
      base_nxt = hpr_pkg::SECTOR_W;
    end else if (hsv.hue < 8'd129) begin
      rgn_nxt  = hpr_pkg::RGN_GC;
      base_nxt = 8'd86;
    end else if (hsv.hue < 8'd172) begin
      rgn_nxt  = hpr_pkg::RGN_CB;
      base_nxt = 8'd129;
    end else if (hsv.hue < 8'd215) begin
      rgn_nxt  = hpr_pkg::RGN_BM;
      base_nxt = 8'd172;
    end else begin
      rgn_nxt  = hpr_pkg::RGN_MR;
      base_nxt = 8'd215;
    end
  end

  assign off_nxt  = hsv.hue - base_nxt;
  assign rem6_nxt = {off_nxt[6:0], 1'b0} + {off_nxt[5:0], 2'b00};
  assign p_prod   = 16'(hsv.val) * 16'(8'hFF - hsv.sat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (rdy2) begin
      vld2_r <= hsv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && hsv_valid) begin
      rgn2_r  <= rgn_nxt;
      rem2_r  <= rem6_nxt;
      p2_r    <= p_prod[15:8];
      v2_r    <= hsv.val;
      s2_r    <= hsv.sat;
      idx2_r  <= hsv.idx;
      gray2_r <= (hsv.sat == 8'd0);
    end
  end

  assign sr_prod = 16'(s2_r) * 16'(rem2_r);
  assign st_prod = 16'(s2_r) * 16'(8'hFF - rem2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (rdy3) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && vld2_r) begin
      rgn3_r  <= rgn2_r;
      sr3_r   <= sr_prod[15:8];
      st3_r   <= st_prod[15:8];
      p3_r    <= p2_r;
      v3_r    <= v2_r;
      idx3_r  <= idx2_r;
      gray3_r <= gray2_r;
    end
  end

  assign q_prod = 16'(v3_r) * 16'(8'hFF - sr3_r);
  assign t_prod = 16'(v3_r) * 16'(8'hFF - st3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (rdy4) begin
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && vld3_r) begin
      rgn4_r  <= rgn3_r;
      q4_r    <= q_prod[15:8];
      t4_r    <= t_prod[15:8];
      p4_r    <= p3_r;
      v4_r    <= v3_r;
      idx4_r  <= idx3_r;
      gray4_r <= gray3_r;
    end
  end

  always_comb begin
    case (hpr_pkg::hpr_region_t'(rgn4_r))
      hpr_pkg::RGN_RY: begin
        red = v4_r; grn = t4_r; blu = p4_r;
      end
      hpr_pkg::RGN_YG: begin
        red = q4_r; grn = v4_r; blu = p4_r;
      end
      hpr_pkg::RGN_GC: begin
        red = p4_r; grn = v4_r; blu = t4_r;
      end
      hpr_pkg::RGN_CB: begin
        red = p4_r; grn = q4_r; blu = v4_r;
      end
      hpr_pkg::RGN_BM: begin
        red = t4_r; grn = p4_r; blu = v4_r;
      end
      default: begin
        red = v4_r; grn = p4_r; blu = q4_r;
      end
    endcase
    if (gray4_r) begin
      red = v4_r;
      grn = v4_r;
      blu = v4_r;
    end
    col_nxt = {red[7:3], grn[7:3], blu[7:3]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else if (rdy5) begin
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && vld4_r) begin
      idx5_r  <= idx4_r;
      col5_r  <= col_nxt;
      gray5_r <= gray4_r;
    end
  end

  assign out_ch.valid       = vld5_r;
  assign out_ch.entry_index = idx5_r;
  assign out_ch.color_word  = col5_r;

  a_gray_equal : assert property (@(posedge clk) disable iff (!rst_n)
    (vld5_r && gray5_r)
      |-> (col5_r[14:10] == col5_r[9:5] && col5_r[9:5] == col5_r[4:0]))
    else $error("gray word with unequal channels");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (vld5_r && !out_ch.ready) |=> (vld5_r && $stable(col5_r) && $stable(idx5_r)))
    else $error("stalled word changed");

  a_stage_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (vld4_r && !rdy5) |=> (vld4_r && $stable(q4_r) && $stable(t4_r)))
    else $error("stage four changed while held");

endmodule

FILE: sv/hsv_palette_ramp_generator.sv
// Top level of the HSV palette ramp generator: settings registers and the five-stage pipeline.
// Takes one slot word per cycle while the output is not stalled and returns its palette
// entry through the five register stages (ramp selection, sector and p product,
// saturation products, q and t products, channel select and packing); stalls at
// the output hold every full stage without losing or repeating a word. Settings are written
// through the cfg port and take effect for slots accepted after the write.
module hsv_palette_ramp_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [hpr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hpr_pkg::CFG_DATA_W-1:0]      cfg_data,
  hpr_slot_if.sink                            in_ch,
  hpr_entry_if.source                         out_ch
);

  hpr_pkg::hpr_cfg_t cfg_r;
  hpr_pkg::hpr_hsv_t hsv;
  logic              hsv_valid;
  logic              hsv_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (hpr_pkg::hpr_cfg_idx_t'(cfg_index))
        hpr_pkg::CFG_RAMP_MODE:  cfg_r.ramp_mode  <= cfg_data[2:0];
        hpr_pkg::CFG_BASE_HUE:   cfg_r.base_hue   <= cfg_data[7:0];
        hpr_pkg::CFG_DESCENDING: cfg_r.descending <= cfg_data[0];
        hpr_pkg::CFG_HUE_SKIP:   cfg_r.hue_skip   <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  hpr_sel u_sel (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .hsv_valid (hsv_valid),
    .hsv       (hsv),
    .hsv_ready (hsv_ready)
  );

  hpr_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .hsv_valid (hsv_valid),
    .hsv       (hsv),
    .hsv_ready (hsv_ready),
    .out_ch    (out_ch)
  );

  a_reset_idle : assert property (@(posedge clk) !$past(rst_n) |-> !out_ch.valid)
    else $error("output valid straight after reset");

endmodule
